@@ src/ebcg_pkg.sv @@
// shared constants, types and helpers for the edge-bounded column gate
// no dependencies; every other file of the block but ebcg_ram depends on this package
package ebcg_pkg;

   localparam int RUN_DEPTH  = 64;
   localparam int PTR_W      = $clog2(RUN_DEPTH);
   localparam int RUN_W      = $clog2(RUN_DEPTH + 1);
   localparam int SUM_W      = RUN_W + 1;
   localparam int ROW_W      = 12;
   localparam int PIX_W      = 8;
   localparam int CFG_RUN_W  = 6;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [CFG_RUN_W-1:0] MIN_RUN_RESET = 6'd0;
   localparam logic [CFG_RUN_W-1:0] MAX_RUN_RESET = 6'd63;
   localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET  = 13'd480;
   localparam logic [HEIGHT_W-1:0]  HEIGHT_LIMIT  = 13'd4096;

   localparam logic [RUN_W-1:0] RUN_SAT  = RUN_W'(RUN_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RUN_DEPTH - 1);

   typedef struct packed {
      logic [CFG_RUN_W-1:0] min_run;
      logic [CFG_RUN_W-1:0] max_run;
      logic [HEIGHT_W-1:0]  image_height;
   } ebcg_cfg_type;

   // what the position tracker knows about the pixel now at the input
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] column;
      logic [PTR_W-1:0] ptr;
      logic             copy;
      logic [PTR_W-1:0] start_ptr;
      logic [ROW_W-1:0] start_row;
      logic [RUN_W-1:0] run;
   } ebcg_item_type;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_LAST) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

endpackage

@@ src/ebcg_channels.sv @@
// valid/ready channel interfaces for pixel beats in and write beats out
// depends on ebcg_pkg for field widths
interface ebcg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          edge_flag;
   logic [ebcg_pkg::PIX_W-1:0]    raw_pixel;

   modport source (output valid, output edge_flag, output raw_pixel, input ready);
   modport sink   (input valid, input edge_flag, input raw_pixel, output ready);
endinterface

interface ebcg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ebcg_pkg::ROW_W-1:0]    write_row;
   logic [ebcg_pkg::ROW_W-1:0]    write_column;
   logic [ebcg_pkg::PIX_W-1:0]    write_value;
   logic                          last_write;

   modport source (output valid, output write_row, output write_column,
                   output write_value, output last_write, input ready);
   modport sink   (input valid, input write_row, input write_column,
                   input write_value, input last_write, output ready);
endinterface

@@ src/ebcg_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module ebcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ebcg_tracker.sv @@
// row, column and run-length tracking, copy-back decision per pixel
// depends on ebcg_pkg
module ebcg_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  ebcg_pkg::ebcg_cfg_type cfg,
   input  logic                   accept,
   input  logic                   edge_flag,
   output ebcg_pkg::ebcg_item_type item
);
   import ebcg_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] col_ff, col_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             counting_ff, counting_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   logic [ROW_W-1:0]    run_x;
   logic [ROW_W-1:0]    min_x;
   logic [ROW_W-1:0]    max_x;
   logic [SUM_W-1:0]    ptr_s;
   logic [SUM_W-1:0]    run_s;
   logic [RUN_W-1:0]    run_a;
   logic [HEIGHT_W-1:0] height_eff;
   logic [HEIGHT_W-1:0] row_p1;
   logic                col_end;

   always_comb begin
      run_x = ROW_W'(run_ff);
      min_x = ROW_W'(cfg.min_run);
      max_x = ROW_W'(cfg.max_run);
      ptr_s = SUM_W'(ptr_ff);
      run_s = SUM_W'(run_ff);

      item.row       = row_ff;
      item.column    = col_ff;
      item.ptr       = ptr_ff;
      item.run       = run_ff;
      item.start_row = row_ff - run_x;
      item.copy      = (run_x >= min_x) && (run_x <= max_x) &&
                       (run_x < ROW_W'(RUN_DEPTH)) && (run_x <= row_ff);
      // buffer slot of the previous edge row, wrapping round the ring
      if (ptr_s >= run_s) begin
         item.start_ptr = PTR_W'(ptr_s - run_s);
      end else begin
         item.start_ptr = PTR_W'(ptr_s + SUM_W'(RUN_DEPTH) - run_s);
      end
   end

   always_comb begin
      counting_in = counting_ff | edge_flag;
      run_a       = edge_flag ? '0 : run_ff;
      if (counting_in && (run_a < RUN_SAT)) begin
         run_in = run_a + 1'b1;
      end else begin
         run_in = run_a;
      end

      height_eff = (cfg.image_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg.image_height;
      row_p1     = HEIGHT_W'(row_ff) + 1'b1;
      col_end    = (row_p1 >= height_eff);

      if (col_end) begin
         row_in      = '0;
         col_in      = col_ff + 1'b1;
         run_in      = '0;
         counting_in = 1'b0;
         ptr_in      = '0;
      end else begin
         row_in = row_p1[ROW_W-1:0];
         col_in = col_ff;
         ptr_in = ptr_step(ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         run_ff      <= '0;
         counting_ff <= 1'b0;
         ptr_ff      <= '0;
      end else if (accept) begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         run_ff      <= run_in;
         counting_ff <= counting_in;
         ptr_ff      <= ptr_in;
      end
   end

endmodule

@@ src/ebcg_seq.sv @@
// sequencer that steps through the copy-back rows one buffer read at a time
// and holds the outgoing write beat; depends on ebcg_pkg and ebcg_rsp_if
module ebcg_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    edge_flag,
   input  logic [ebcg_pkg::PIX_W-1:0] raw_pixel,
   input  ebcg_pkg::ebcg_item_type item,
   output logic                    idle,
   output logic                    rd_en,
   output logic [ebcg_pkg::PTR_W-1:0] rd_addr,
   input  logic [ebcg_pkg::PIX_W-1:0] rd_data,
   ebcg_rsp_if.source              rsp_chan
);
   import ebcg_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_LAST = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [ROW_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0] last_val_ff, last_val_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ROW_W-1:0] rd_row_ff, rd_row_in;
   logic [RUN_W-1:0] remain_ff, remain_in;
   logic             out_valid_ff, out_valid_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [ROW_W-1:0] out_col_ff, out_col_in;
   logic [PIX_W-1:0] out_val_ff, out_val_in;
   logic             out_last_ff, out_last_in;
   logic             slot_free;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign idle      = (state_ff == S_IDLE);
   assign rd_en     = (state_ff == S_READ);
   assign rd_addr   = rd_ptr_ff;

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      col_in       = col_ff;
      last_val_in  = last_val_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_row_in    = rd_row_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_row_in = item.row;
               col_in     = item.column;
               if (!edge_flag) begin
                  last_val_in = '0;
                  state_in    = S_LAST;
               end else if (item.copy) begin
                  // current row comes straight from the beat, older rows from the buffer
                  last_val_in = raw_pixel;
                  rd_ptr_in   = item.start_ptr;
                  rd_row_in   = item.start_row;
                  remain_in   = item.run;
                  state_in    = (item.run == '0) ? S_LAST : S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_row_in   = rd_row_ff;
               out_col_in   = col_ff;
               out_val_in   = rd_data;
               out_last_in  = 1'b0;
               rd_row_in    = rd_row_ff + 1'b1;
               rd_ptr_in    = ptr_step(rd_ptr_ff);
               remain_in    = remain_ff - 1'b1;
               state_in     = (remain_ff == RUN_W'(1)) ? S_LAST : S_READ;
            end
         end
         S_LAST: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_row_in   = cur_row_ff;
               out_col_in   = col_ff;
               out_val_in   = last_val_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff  <= cur_row_in;
      col_ff      <= col_in;
      last_val_ff <= last_val_in;
      rd_ptr_ff   <= rd_ptr_in;
      rd_row_ff   <= rd_row_in;
      remain_ff   <= remain_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.write_row    = out_row_ff;
   assign rsp_chan.write_column = out_col_ff;
   assign rsp_chan.write_value  = out_val_ff;
   assign rsp_chan.last_write   = out_last_ff;

endmodule

@@ src/edge_bounded_column_gate_core.sv @@
// a non-edge pixel beat gives one write beat, from S_LAST; an edge copied back over
// distance d gives d + 1 write beats, paced by the single read port of the column
// buffer (one read, then one write beat, per older row, then the final beat);
// an edge that is not copied gives no write beat. one pixel in flight at a time.
// reset (synchronous, active high) clears position, run length and config to defaults;
// the column buffer is not cleared and needs no clearing pass.
module edge_bounded_column_gate_core (
   input  logic                           clock,
   input  logic                           reset,
   ebcg_req_if.sink                       req_chan,
   ebcg_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [ebcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebcg_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ebcg_pkg::*;

   logic [CFG_RUN_W-1:0] min_run_ff;
   logic [CFG_RUN_W-1:0] max_run_ff;
   logic [HEIGHT_W-1:0]  height_ff;

   ebcg_cfg_type  cfg;
   ebcg_item_type item;
   logic          accept;
   logic          idle;
   logic          rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [PIX_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MIN_RUN_RESET;
         max_run_ff <= MAX_RUN_RESET;
         height_ff  <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_RUN:      min_run_ff <= csr_write_data[CFG_RUN_W-1:0];
            CSR_MAX_RUN:      max_run_ff <= csr_write_data[CFG_RUN_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_write_data[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.min_run      = min_run_ff;
   assign cfg.max_run      = max_run_ff;
   assign cfg.image_height = height_ff;

   assign req_chan.ready = idle;
   assign accept         = req_chan.valid && idle;

   ebcg_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .edge_flag (req_chan.edge_flag),
      .item      (item)
   );

   ebcg_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RUN_DEPTH)
   ) u_column_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (item.ptr),
      .wr_data (req_chan.raw_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ebcg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .edge_flag (req_chan.edge_flag),
      .raw_pixel (req_chan.raw_pixel),
      .item      (item),
      .idle      (idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ src/ebcg_checker.sv @@
// port-level checks on the column gate's channels over time
// depends on ebcg_pkg; bound to edge_bounded_column_gate_core below
module ebcg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ebcg_pkg::ROW_W-1:0] rsp_write_row,
   input logic [ebcg_pkg::ROW_W-1:0] rsp_write_column,
   input logic [ebcg_pkg::PIX_W-1:0] rsp_write_value,
   input logic                       rsp_last_write
);
   import ebcg_pkg::*;

   // a held write beat does not change under backpressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_row) &&
      $stable(rsp_write_column) && $stable(rsp_write_value) && $stable(rsp_last_write))
      else $error("write beat changed while stalled");

   // no new pixel while a copy-back burst is unfinished
   a_burst_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_write |-> !req_ready)
      else $error("pixel taken during copy-back burst");

   // a non-final beat leaving means more beats of this pixel follow
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_write |=>
      !req_ready || (rsp_valid && rsp_last_write))
      else $error("burst ended without a final beat");

endmodule

bind edge_bounded_column_gate_core ebcg_checker u_ebcg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_write_row    (rsp_chan.write_row),
   .rsp_write_column (rsp_chan.write_column),
   .rsp_write_value  (rsp_chan.write_value),
   .rsp_last_write   (rsp_chan.last_write)
);
